// ===== design/brbp_pkg.sv =====
// ----------------------------------------------------------------------------
// brbp_pkg - shared types and constants of the byte ring buffer with peek
// Operation codes, status codes and default sizing used by the top level
// and by its port checker.
// ----------------------------------------------------------------------------
`default_nettype none

package brbp_pkg;

	// operation code carried with each input word
	typedef enum logic [1:0] {
		FUNC_PUSH  = 2'd0,
		FUNC_POP   = 2'd1,
		FUNC_PEEK  = 2'd2,
		FUNC_CLEAR = 2'd3
	} func_t;

	// result status
	localparam logic STATUS_DONE    = 1'b0;
	localparam logic STATUS_REFUSED = 1'b1;

	// default ring sizing and capacity register reset
	localparam int          DEF_MAX_CAPACITY = 255;
	localparam logic [7:0]  CAP_RESET        = 8'd255;

endpackage : brbp_pkg

`default_nettype wire

// ===== design/brbp_store.sv =====
// ----------------------------------------------------------------------------
// brbp_store - byte storage of the ring buffer
// Single-port-write, single-port-read memory with a registered read port.
// Read data holds until the next read enable.
// ----------------------------------------------------------------------------
`default_nettype none

module brbp_store #(
	parameter int DEPTH  = 256,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [7:0]        wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [7:0]        rdata
);

	logic [7:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule : brbp_store

`default_nettype wire

// ===== design/byte_ring_buffer_with_peek.sv =====
// ----------------------------------------------------------------------------
// byte_ring_buffer_with_peek - byte circular buffer with push, pop, peek, clear
// Ring of capacity+1 slots with one slot kept empty; bytes live in a memory
// with a registered read port, pointers and block state live in flops.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one operation word: func,
//   data, first_of_block, amount. Output channel (out_valid / out_stall)
//   returns exactly one result word per operation: status, read_byte,
//   fill_count, is_empty, in order.
//   Latency: the result is valid in the cycle after the operation is taken.
//   Throughput: one operation per cycle while the output is drained; the
//   pointers update at the accept edge and the memory read of a peek is
//   issued at that same edge, so a following operation sees the new state.
//   When the receiver stalls, the result register holds and in_stall rises
//   in the same cycle, so at most one finished result waits.
//   Reset (arst_n low) empties the buffer, clears the pointers and block
//   state, sets capacity to its reset value and drops any pending result.
//   A write on cfg_we sets the capacity register and empties the buffer;
//   the user issues it only while no operation is pending (unenforced).
//   Stored bytes are not cleared; only bytes written since can be peeked.
// ----------------------------------------------------------------------------
`default_nettype none

module byte_ring_buffer_with_peek #(
	parameter int MAX_CAPACITY = brbp_pkg::DEF_MAX_CAPACITY
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	// capacity register write
	input  wire logic             cfg_we,
	input  wire logic [7:0]       cfg_wdata,
	// operation channel
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire brbp_pkg::func_t  func,
	input  wire logic [7:0]       data,
	input  wire logic             first_of_block,
	input  wire logic [7:0]       amount,
	// result channel
	output logic                  out_valid,
	input  wire logic             out_stall,
	output logic                  status,
	output logic      [7:0]       read_byte,
	output logic      [7:0]       fill_count,
	output logic                  is_empty
);

	import brbp_pkg::*;

	localparam int DEPTH   = MAX_CAPACITY + 1;
	localparam int IDX_W   = $clog2(DEPTH);
	localparam int AW      = (IDX_W > 8) ? IDX_W : 8;
	localparam int SW      = AW + 1;
	localparam int CAP_RST_INT = (int'(CAP_RESET) > MAX_CAPACITY) ? MAX_CAPACITY
		: ((int'(CAP_RESET) < 1) ? 1 : int'(CAP_RESET));
	localparam logic [AW-1:0] CAP_MAX = AW'(MAX_CAPACITY);
	localparam logic [AW-1:0] CAP_RST = AW'(CAP_RST_INT);
	localparam logic [AW-1:0] ONE_AW  = AW'(1);

	// state registers
	logic [AW-1:0]    cap_q;
	logic [IDX_W-1:0] front_q;
	logic [IDX_W-1:0] rear_q;
	logic             blk_acc_q;

	// result registers
	logic             out_valid_q;
	logic             status_q;
	logic             peek_ok_q;
	logic [7:0]       fill_q;
	logic             empty_q;

	logic             accept;
	logic [AW-1:0]    cfg_w;
	logic [AW-1:0]    cap_eff;
	logic [AW-1:0]    front_w;
	logic [AW-1:0]    rear_w;
	logic [SW-1:0]    slots;
	logic [SW-1:0]    fill_wide;
	logic [AW-1:0]    fill;
	logic [AW-1:0]    amt_w;
	logic [AW-1:0]    blk_len;
	logic             blk_acc_nxt;
	logic             push_ok;
	logic [IDX_W-1:0] rear_inc;
	logic [SW-1:0]    pop_sum;
	logic [SW-1:0]    pop_wrap;
	logic [SW-1:0]    peek_sum;
	logic [SW-1:0]    peek_wrap;
	logic             pop_ok;
	logic             peek_ok;
	logic [IDX_W-1:0] front_nxt;
	logic [IDX_W-1:0] rear_nxt;
	logic             blk_acc_upd;
	logic [AW-1:0]    fill_nxt;
	logic             status_nxt;
	logic [7:0]       rdata;

	// handshake: hold input while a result waits on a stalled receiver
	assign in_stall  = out_valid_q & out_stall;
	assign accept    = in_valid & ~in_stall;
	assign out_valid = out_valid_q;

	// effective capacity of a register write, clipped to 1..MAX_CAPACITY
	always_comb begin
		cfg_w = AW'(cfg_wdata);
		if (cfg_w == '0) begin
			cap_eff = ONE_AW;
		end else if (cfg_w > CAP_MAX) begin
			cap_eff = CAP_MAX;
		end else begin
			cap_eff = cfg_w;
		end
	end

	// current fill from the two pointers
	always_comb begin
		front_w = AW'(front_q);
		rear_w  = AW'(rear_q);
		slots   = SW'(cap_q) + SW'(1);
		if (rear_w >= front_w) begin
			fill_wide = SW'(rear_w) - SW'(front_w);
		end else begin
			fill_wide = slots + SW'(rear_w) - SW'(front_w);
		end
		fill = fill_wide[AW-1:0];
	end

	// push: block space check and rear advance
	always_comb begin
		amt_w       = AW'(amount);
		blk_len     = (amt_w == '0) ? ONE_AW : amt_w;
		blk_acc_nxt = first_of_block ? (blk_len <= (cap_q - fill)) : blk_acc_q;
		push_ok     = blk_acc_nxt & (fill < cap_q);
		rear_inc    = (rear_w == cap_q) ? '0 : rear_q + IDX_W'(1);
	end

	// pop and peek: front plus amount, wrapped once at the slot count
	always_comb begin
		pop_sum   = SW'(front_w) + SW'(amt_w);
		pop_wrap  = (pop_sum >= slots) ? pop_sum - slots : pop_sum;
		peek_sum  = pop_sum - SW'(1);
		peek_wrap = (peek_sum >= slots) ? peek_sum - slots : peek_sum;
		pop_ok    = (amt_w <= fill);
		peek_ok   = (amt_w != '0) && (amt_w <= fill);
	end

	// next pointers, fill and status for the accepted operation
	always_comb begin
		front_nxt   = front_q;
		rear_nxt    = rear_q;
		blk_acc_upd = blk_acc_q;
		fill_nxt    = fill;
		status_nxt  = STATUS_DONE;
		unique case (func)
			FUNC_PUSH: begin
				blk_acc_upd = blk_acc_nxt;
				if (push_ok) begin
					rear_nxt = rear_inc;
					fill_nxt = fill + ONE_AW;
				end else begin
					status_nxt = STATUS_REFUSED;
				end
			end
			FUNC_POP: begin
				if (pop_ok) begin
					front_nxt = pop_wrap[IDX_W-1:0];
					fill_nxt  = fill - amt_w;
				end else begin
					status_nxt = STATUS_REFUSED;
				end
			end
			FUNC_PEEK: begin
				if (!peek_ok) begin
					status_nxt = STATUS_REFUSED;
				end
			end
			FUNC_CLEAR: begin
				front_nxt = rear_q;
				fill_nxt  = '0;
			end
			default: begin
				status_nxt = STATUS_REFUSED;
			end
		endcase
	end

	// pointer, capacity and block state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q     <= CAP_RST;
			front_q   <= '0;
			rear_q    <= '0;
			blk_acc_q <= 1'b0;
		end else if (cfg_we) begin
			cap_q     <= cap_eff;
			front_q   <= '0;
			rear_q    <= '0;
			blk_acc_q <= 1'b0;
		end else if (accept) begin
			front_q   <= front_nxt;
			rear_q    <= rear_nxt;
			blk_acc_q <= blk_acc_upd;
		end
	end

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			status_q  <= status_nxt;
			peek_ok_q <= (func == FUNC_PEEK) && peek_ok;
			fill_q    <= fill_nxt[7:0];
			empty_q   <= (fill_nxt == '0);
		end
	end

	// byte memory: push writes at rear, peek reads at front plus position
	brbp_store #(
		.DEPTH  (DEPTH),
		.ADDR_W (IDX_W)
	) u_store (
		.clk   (clk),
		.we    (accept && (func == FUNC_PUSH) && push_ok && !cfg_we),
		.waddr (rear_q),
		.wdata (data),
		.re    (accept && (func == FUNC_PEEK) && peek_ok),
		.raddr (peek_wrap[IDX_W-1:0]),
		.rdata (rdata)
	);

	// result ports
	assign status     = status_q;
	assign read_byte  = peek_ok_q ? rdata : 8'd0;
	assign fill_count = fill_q;
	assign is_empty   = empty_q;

endmodule : byte_ring_buffer_with_peek

`default_nettype wire

// ===== design/brbp_checker.sv =====
// ----------------------------------------------------------------------------
// brbp_checker - port-level checks of the byte ring buffer with peek
// Watches the top level's ports over time; attached by the bind below.
// ----------------------------------------------------------------------------
`default_nettype none

module brbp_checker (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire logic             in_stall,
	input  wire logic             out_valid,
	input  wire logic             out_stall,
	input  wire logic             status,
	input  wire logic [7:0]       read_byte,
	input  wire logic [7:0]       fill_count,
	input  wire logic             is_empty
);

	import brbp_pkg::*;

	// a stalled result word holds
	property p_out_hold;
		@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(status) &&
			$stable(read_byte) && $stable(fill_count) && $stable(is_empty));
	endproperty
	a_out_hold: assert property (p_out_hold)
		else $error("result word changed while stalled");

	// every accepted operation shows a result in the next cycle
	property p_one_cycle;
		@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> out_valid;
	endproperty
	a_one_cycle: assert property (p_one_cycle)
		else $error("no result one cycle after an accepted operation");

	// empty flag agrees with the fill count
	property p_empty_fill;
		@(posedge clk) disable iff (!arst_n)
		out_valid |-> (is_empty == (fill_count == 8'd0));
	endproperty
	a_empty_fill: assert property (p_empty_fill)
		else $error("is_empty disagrees with fill_count");

	// a refused operation returns no data
	property p_refused_zero;
		@(posedge clk) disable iff (!arst_n)
		(out_valid && (status == STATUS_REFUSED)) |-> (read_byte == 8'd0);
	endproperty
	a_refused_zero: assert property (p_refused_zero)
		else $error("refused operation returned a nonzero byte");

endmodule : brbp_checker

bind byte_ring_buffer_with_peek brbp_checker u_brbp_checker (.*);

`default_nettype wire
